// ===== design/trial_division_prime_test_macros.svh =====
// Assertion macros shared by the checker of the trial-division prime test.
`ifndef TRIAL_DIVISION_PRIME_TEST_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TDPT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TDPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Implication that also holds across reset.
`define TDPT_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== design/tdpt_pkg.sv =====
// Shared constants and types of the trial-division prime test.
package tdpt_pkg;

  localparam int NUMBER_WIDTH = 32;
  // Width of the trial divisor 6k+1 and of the 6k counter.
  localparam int SW = (NUMBER_WIDTH + 1) / 2 + 1;
  // Width of the running square (6k)^2.
  localparam int SQW = NUMBER_WIDTH + 2;
  localparam int CNT_W = $clog2(NUMBER_WIDTH);
  localparam int S_DATA_W = ((NUMBER_WIDTH + 7) / 8) * 8;
  localparam int M_DATA_W = 8;

  typedef struct packed {
    logic                    start;
    logic [NUMBER_WIDTH-1:0] dividend;
    logic [SW-1:0]           divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } div_status_t;

endpackage

// ===== design/trial_division_prime_test.sv =====
// Top level of the trial-division prime test: sequencer, wheel counters and result register.
//
// One request on the slave stream carries an unsigned number in s_tdata; the block answers
// with one request on the master stream whose bit 0 of m_tdata is 1 when the number is prime.
// The numbers 2, 3, 5 and 7 are prime, 0 and 1 are not, and even numbers other than 2 are
// rejected at once; for these cases the classify state passes straight to the finish state.
// Any other number first goes through a division by 3, then through rounds k = 1, 2, ...
// that divide by 6k-1 and 6k+1. A round continues while (6k)^2 <= number, the square being
// kept by additions alone. All divisions share one serial divider that handles one bit of
// the number per cycle. For 32-bit numbers the worst case is a prime near 2^32 with 10923 rounds.
// The block works on one number at a time: s_tready is high only while it is idle.
// The result sits in an output register, so a new number may be accepted while the
// previous result still waits; if the receiver stalls and the next result is ready, the
// sequencer holds it until the output register empties.
// A synchronous reset returns the sequencer to idle and empties the output register.
module trial_division_prime_test (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [tdpt_pkg::S_DATA_W-1:0] s_tdata,  // [NUMBER_WIDTH-1:0] number
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [tdpt_pkg::M_DATA_W-1:0] m_tdata   // [0] prime_flag, zeros above
);
  import tdpt_pkg::*;

  localparam logic [2:0] ST_IDLE       = 3'd0;
  localparam logic [2:0] ST_CLASSIFY   = 3'd1;
  localparam logic [2:0] ST_DIV_START  = 3'd2;
  localparam logic [2:0] ST_DIV_WAIT   = 3'd3;
  localparam logic [2:0] ST_ROUND_NEXT = 3'd4;
  localparam logic [2:0] ST_FINISH     = 3'd5;

  localparam logic [1:0] PH_THREE = 2'd0;
  localparam logic [1:0] PH_LOW   = 2'd1;
  localparam logic [1:0] PH_HIGH  = 2'd2;

  logic [2:0]              state;
  logic [1:0]              phase;
  logic [NUMBER_WIDTH-1:0] n;
  logic [SW-1:0]           six_k;
  logic [SQW-1:0]          sq;
  logic                    result;
  logic                    prime;
  logic [SW-1:0]           divisor;
  div_req_t                div_req;
  div_status_t             div_status;

  // Divisor for the current phase: 3 before the wheel, then 6k-1 and 6k+1.
  always_comb begin
    case (phase)
      PH_THREE: divisor = SW'(3);
      PH_LOW:   divisor = six_k - 1'b1;
      PH_HIGH:  divisor = six_k + 1'b1;
      default:  divisor = SW'(3);
    endcase
  end

  assign div_req.start    = (state == ST_DIV_START);
  assign div_req.dividend = n;
  assign div_req.divisor  = divisor;

  tdpt_divider u_divider (
    .clk    (clk),
    .rst    (rst),
    .req    (div_req),
    .status (div_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      phase    <= PH_THREE;
      m_tvalid <= 1'b0;
    end else begin
      // In the finish state the output register is refilled below instead.
      if (m_tvalid && m_tready && state != ST_FINISH) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            n     <= s_tdata[NUMBER_WIDTH-1:0];
            state <= ST_CLASSIFY;
          end
        end
        ST_CLASSIFY: begin
          // Small primes first, then zero, one and the even numbers.
          if (n == NUMBER_WIDTH'(2) || n == NUMBER_WIDTH'(3) ||
              n == NUMBER_WIDTH'(5) || n == NUMBER_WIDTH'(7)) begin
            result <= 1'b1;
            state  <= ST_FINISH;
          end else if (n < NUMBER_WIDTH'(2) || !n[0]) begin
            result <= 1'b0;
            state  <= ST_FINISH;
          end else begin
            phase <= PH_THREE;
            six_k <= SW'(6);
            sq    <= SQW'(36);
            state <= ST_DIV_START;
          end
        end
        ST_DIV_START: begin
          state <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_status.done) begin
            if (div_status.rem_zero) begin
              result <= 1'b0;
              state  <= ST_FINISH;
            end else begin
              case (phase)
                PH_THREE: begin
                  phase <= PH_LOW;
                  state <= ST_DIV_START;
                end
                PH_LOW: begin
                  phase <= PH_HIGH;
                  state <= ST_DIV_START;
                end
                default: begin
                  state <= ST_ROUND_NEXT;
                end
              endcase
            end
          end
        end
        ST_ROUND_NEXT: begin
          // Another round while (6k)^2 <= n; (6k+6)^2 = (6k)^2 + 12(6k) + 36.
          if (sq <= {2'b00, n}) begin
            sq    <= sq + SQW'({six_k, 3'b000}) + SQW'({six_k, 2'b00}) + SQW'(36);
            six_k <= six_k + SW'(6);
            phase <= PH_LOW;
            state <= ST_DIV_START;
          end else begin
            result <= 1'b1;
            state  <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            prime    <= result;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = {{(M_DATA_W-1){1'b0}}, prime};

endmodule

// ===== design/tdpt_divider.sv =====
// Serial restoring divider that works through one dividend bit a cycle and reports whether the remainder is zero.
module tdpt_divider (
  input  logic                 clk,
  input  logic                 rst,
  input  tdpt_pkg::div_req_t   req,
  output tdpt_pkg::div_status_t status
);
  import tdpt_pkg::*;

  logic                    busy;
  logic                    done;
  logic [CNT_W-1:0]        cnt;
  logic [SW-1:0]           rem;
  logic [SW-1:0]           divisor;
  logic [NUMBER_WIDTH-1:0] dv;
  logic [SW:0]             trial;

  assign trial = {rem, dv[NUMBER_WIDTH-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy    <= 1'b1;
        cnt     <= '0;
        rem     <= '0;
        dv      <= req.dividend;
        divisor <= req.divisor;
      end else if (busy) begin
        if (trial >= {1'b0, divisor}) begin
          rem <= SW'(trial - {1'b0, divisor});
        end else begin
          rem <= trial[SW-1:0];
        end
        dv <= {dv[NUMBER_WIDTH-2:0], 1'b0};
        if (cnt == CNT_W'(NUMBER_WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  assign status.done     = done;
  assign status.rem_zero = (rem == '0);

endmodule

// ===== design/tdpt_checker.sv =====
// Port-level assertions for the trial-division prime test, bound to the top level.
`include "trial_division_prime_test_macros.svh"

module tdpt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [tdpt_pkg::S_DATA_W-1:0] s_tdata,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [tdpt_pkg::M_DATA_W-1:0] m_tdata
);
  import tdpt_pkg::*;

  logic unused_data;
  assign unused_data = ^s_tdata;

  // A stalled result stays put.
  `TDPT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")

  // The block takes one number at a time.
  `TDPT_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "input still ready right after a request")

  // Only the flag bit of the result may be set.
  `TDPT_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[M_DATA_W-1:1] == '0, "padding bits of result not zero")

  // Reset leaves the block idle with no result pending.
  `TDPT_ASSERT_ALWAYS(a_reset_state, $past(rst) && !rst, s_tready && !m_tvalid, "block not idle after reset")

endmodule

bind trial_division_prime_test tdpt_checker u_tdpt_checker (.*);
